// ===== hw/rtl/tcsb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Text console scroll buffer package
// Shared constants, configuration type and width helper for the console
// scroll buffer.
// ----------------------------------------------------------------------------
package tcsb_pkg;

  localparam int MAX_ROWS_DEF = 8;
  localparam int MAX_COLS_DEF = 32;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_ROWS = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLS = 4'd1;

  localparam logic [3:0] ROWS_RESET = 4'd8;
  localparam logic [4:0] COLS_RESET = 5'd31;

  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_CLEAR  = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  localparam logic [7:0] CHAR_NUL = 8'd0;
  localparam logic [7:0] CHAR_LF  = 8'd10;
  localparam logic [7:0] CHAR_CR  = 8'd13;

  typedef struct packed {
    logic [3:0] rows_in_use;
    logic [4:0] cols_in_use;
  } cfg_t;

  function automatic int addr_bits(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tcsb_screen_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Screen cell memory
// One write port and one read port with registered read data. Cells are
// addressed by row and column fields joined together.
// ----------------------------------------------------------------------------
module tcsb_screen_ram #(
  parameter int MAX_ROWS = tcsb_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = tcsb_pkg::MAX_COLS_DEF
) (
  input  wire logic clk,
  input  wire logic we,
  input  wire logic [tcsb_pkg::addr_bits(MAX_ROWS)+tcsb_pkg::addr_bits(MAX_COLS)-1:0] waddr,
  input  wire logic [7:0] wdata,
  input  wire logic [tcsb_pkg::addr_bits(MAX_ROWS)+tcsb_pkg::addr_bits(MAX_COLS)-1:0] raddr,
  output logic [7:0] rdata
);
  import tcsb_pkg::*;

  localparam int CW    = addr_bits(MAX_COLS);
  localparam int DEPTH = MAX_ROWS * (2 ** CW);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tcsb_line_buf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Line buffer
// Holds the line being typed. Per-entry valid bits make every entry read as
// zero until it is first written after reset.
// ----------------------------------------------------------------------------
module tcsb_line_buf #(
  parameter int MAX_COLS = tcsb_pkg::MAX_COLS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic we,
  input  wire logic [tcsb_pkg::addr_bits(MAX_COLS)-1:0] waddr,
  input  wire logic [7:0] wdata,
  input  wire logic [tcsb_pkg::addr_bits(MAX_COLS)-1:0] raddr,
  output logic [7:0] rdata
);
  import tcsb_pkg::*;

  logic [7:0]          mem [MAX_COLS];
  logic [MAX_COLS-1:0] valid;
  logic [7:0]          rd_data;
  logic                rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data  <= mem[raddr];
    rd_valid <= valid[raddr];
  end

  assign rdata = rd_valid ? rd_data : CHAR_NUL;

endmodule
`default_nettype wire

// ===== hw/rtl/tcsb_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Console sequencer
// Decodes each item, steps the shared screen write port over the screen for
// scroll and commit, clear and the clearing pass after reset, and serves reads.
// ----------------------------------------------------------------------------
module tcsb_ctrl #(
  parameter int MAX_ROWS = tcsb_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = tcsb_pkg::MAX_COLS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire tcsb_pkg::cfg_t cfg,
  input  wire logic start,
  input  wire logic [1:0] action,
  input  wire logic [7:0] char_code,
  input  wire logic [2:0] row_index,
  input  wire logic [4:0] col_index,
  output logic busy,
  output logic done,
  output logic [7:0] read_data,
  output logic redraw,
  output logic [4:0] line_length,
  output logic scr_we,
  output logic [tcsb_pkg::addr_bits(MAX_ROWS)+tcsb_pkg::addr_bits(MAX_COLS)-1:0] scr_waddr,
  output logic [7:0] scr_wdata,
  output logic [tcsb_pkg::addr_bits(MAX_ROWS)+tcsb_pkg::addr_bits(MAX_COLS)-1:0] scr_raddr,
  input  wire logic [7:0] scr_rdata,
  output logic line_we,
  output logic [tcsb_pkg::addr_bits(MAX_COLS)-1:0] line_waddr,
  output logic [7:0] line_wdata,
  output logic [tcsb_pkg::addr_bits(MAX_COLS)-1:0] line_raddr,
  input  wire logic [7:0] line_rdata
);
  import tcsb_pkg::*;

  localparam int RW = addr_bits(MAX_ROWS);
  localparam int CW = addr_bits(MAX_COLS);

  typedef enum logic [7:0] {
    S_INIT  = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_COPY  = 8'b0000_0100,
    S_FLUSH = 8'b0000_1000,
    S_CLEAR = 8'b0001_0000,
    S_CHAR  = 8'b0010_0000,
    S_TERM  = 8'b0100_0000,
    S_READ  = 8'b1000_0000
  } state_t;

  state_t         state;
  logic [RW-1:0]  ri;
  logic [CW-1:0]  cj;
  logic [RW-1:0]  lim_r;
  logic [CW-1:0]  lim_c;
  logic [CW-1:0]  wp;
  logic [7:0]     code_q;
  logic           pend_char;
  logic           committed;
  logic           rd_ok;
  logic           pw_valid;
  logic [RW+CW-1:0] pw_addr;
  logic           pw_line;

  logic [RW-1:0]  last_r;
  logic [CW-1:0]  last_c;
  logic [RW-1:0]  ri_inc;
  logic [CW-1:0]  wp_inc;
  logic           in_copy;

  always_comb begin
    if (cfg.rows_in_use == '0) begin
      last_r = '0;
    end else if (int'(cfg.rows_in_use) > MAX_ROWS) begin
      last_r = RW'(MAX_ROWS - 1);
    end else begin
      last_r = RW'(cfg.rows_in_use - 4'd1);
    end
    if (cfg.cols_in_use == '0) begin
      last_c = '0;
    end else if (int'(cfg.cols_in_use) > MAX_COLS - 1) begin
      last_c = CW'(MAX_COLS - 2);
    end else begin
      last_c = CW'(cfg.cols_in_use - 5'd1);
    end
  end

  assign ri_inc      = ri + 1'b1;
  assign wp_inc      = wp + 1'b1;
  assign in_copy     = (state == S_COPY) || (state == S_FLUSH);
  assign busy        = (state != S_IDLE);
  assign line_length = 5'(wp);

  always_comb begin
    scr_we     = (in_copy && pw_valid) || (state == S_CLEAR) || (state == S_INIT);
    scr_waddr  = in_copy ? pw_addr : {ri, cj};
    scr_wdata  = in_copy ? (pw_line ? line_rdata : scr_rdata) : CHAR_NUL;
    scr_raddr  = (state == S_IDLE) ? {RW'(row_index), CW'(col_index)} : {ri_inc, cj};
    line_raddr = cj;
    line_we    = (state == S_FLUSH) || (state == S_CHAR) || (state == S_TERM);
    line_wdata = (state == S_CHAR) ? code_q : CHAR_NUL;
    priority if (state == S_FLUSH) begin
      line_waddr = '0;
    end else if (state == S_CHAR) begin
      line_waddr = wp;
    end else begin
      line_waddr = wp_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      ri        <= '0;
      cj        <= '0;
      lim_r     <= RW'(MAX_ROWS - 1);
      lim_c     <= CW'(MAX_COLS - 1);
      wp        <= '0;
      pend_char <= 1'b0;
      committed <= 1'b0;
      pw_valid  <= 1'b0;
      done      <= 1'b0;
      read_data <= '0;
      redraw    <= 1'b0;
    end else begin
      unique case (state)
        S_INIT, S_CLEAR: begin
          if (cj == lim_c) begin
            cj <= '0;
            if (ri == lim_r) begin
              ri    <= '0;
              state <= S_IDLE;
              if (state == S_CLEAR) begin
                done      <= 1'b1;
                read_data <= '0;
                redraw    <= 1'b0;
              end
            end else begin
              ri <= ri_inc;
            end
          end else begin
            cj <= cj + 1'b1;
          end
        end
        S_IDLE: begin
          done <= start &&
                  (((action == ACT_APPEND) && (char_code == CHAR_CR)) ||
                   ((action != ACT_APPEND) && (action != ACT_CLEAR) &&
                    (action != ACT_READ)));
          if (start) begin
            ri     <= '0;
            cj     <= '0;
            lim_r  <= last_r;
            lim_c  <= last_c;
            code_q <= char_code;
            rd_ok  <= (int'(row_index) < MAX_ROWS) && (int'(col_index) < MAX_COLS);
            unique case (action)
              ACT_APPEND: begin
                if (char_code == CHAR_LF) begin
                  pend_char <= 1'b0;
                  committed <= 1'b1;
                  state     <= S_COPY;
                end else if (char_code == CHAR_CR) begin
                  read_data <= '0;
                  redraw    <= 1'b0;
                end else if (wp >= last_c) begin
                  pend_char <= 1'b1;
                  committed <= 1'b1;
                  state     <= S_COPY;
                end else begin
                  committed <= 1'b0;
                  state     <= S_CHAR;
                end
              end
              ACT_CLEAR: begin
                state <= S_CLEAR;
              end
              ACT_READ: begin
                state <= S_READ;
              end
              default: begin
                read_data <= '0;
                redraw    <= 1'b0;
              end
            endcase
          end
        end
        S_COPY: begin
          pw_valid <= 1'b1;
          pw_addr  <= {ri, cj};
          pw_line  <= (ri == lim_r);
          if (ri == lim_r) begin
            ri <= '0;
            if (cj == lim_c) begin
              state <= S_FLUSH;
            end else begin
              cj <= cj + 1'b1;
            end
          end else begin
            ri <= ri_inc;
          end
        end
        S_FLUSH: begin
          pw_valid <= 1'b0;
          wp       <= '0;
          if (pend_char) begin
            state <= S_CHAR;
          end else begin
            state     <= S_IDLE;
            done      <= 1'b1;
            read_data <= '0;
            redraw    <= 1'b1;
          end
        end
        S_CHAR: begin
          state <= S_TERM;
        end
        S_TERM: begin
          wp        <= wp_inc;
          state     <= S_IDLE;
          done      <= 1'b1;
          read_data <= '0;
          redraw    <= committed;
        end
        S_READ: begin
          state     <= S_IDLE;
          done      <= 1'b1;
          read_data <= rd_ok ? scr_rdata : CHAR_NUL;
          redraw    <= 1'b0;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/text_console_scroll_buffer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Text console scroll buffer
// Character console with a line buffer and a scrolling screen grid.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low, and its single result
// appears on read_data, redraw and line_length for exactly one cycle with
// done high; the receiver must take it then, as it cannot stall. A carriage
// return or an unused action finishes without raising busy; a read, an
// ordinary character and a clear of the rows x columns in use hold busy
// high until the result. A newline, or a character that fills the line,
// scrolls the screen through the screen memory ports at one cell per cycle,
// and such a character is then stored at the start of the line. After reset
// the block clears all MAX_ROWS x MAX_COLS cells in a pass with busy high;
// configuration writes are taken at any time but are meant for idle periods.
// ----------------------------------------------------------------------------
module text_console_scroll_buffer #(
  parameter int MAX_ROWS = tcsb_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = tcsb_pkg::MAX_COLS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire logic [1:0] action,
  input  wire logic [7:0] char_code,
  input  wire logic [2:0] row_index,
  input  wire logic [4:0] col_index,
  output logic done,
  output logic [7:0] read_data,
  output logic redraw,
  output logic [4:0] line_length,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [tcsb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tcsb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tcsb_pkg::*;

  localparam int RW = addr_bits(MAX_ROWS);
  localparam int CW = addr_bits(MAX_COLS);

  cfg_t cfg;

  logic             scr_we;
  logic [RW+CW-1:0] scr_waddr;
  logic [7:0]       scr_wdata;
  logic [RW+CW-1:0] scr_raddr;
  logic [7:0]       scr_rdata;
  logic             line_we;
  logic [CW-1:0]    line_waddr;
  logic [7:0]       line_wdata;
  logic [CW-1:0]    line_raddr;
  logic [7:0]       line_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rows_in_use <= ROWS_RESET;
      cfg.cols_in_use <= COLS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_ROWS) begin
        cfg.rows_in_use <= cfg_data[3:0];
      end
      if (cfg_index == REG_COLS) begin
        cfg.cols_in_use <= cfg_data[4:0];
      end
    end
  end

  tcsb_ctrl #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .start      (start),
    .action     (action),
    .char_code  (char_code),
    .row_index  (row_index),
    .col_index  (col_index),
    .busy       (busy),
    .done       (done),
    .read_data  (read_data),
    .redraw     (redraw),
    .line_length(line_length),
    .scr_we     (scr_we),
    .scr_waddr  (scr_waddr),
    .scr_wdata  (scr_wdata),
    .scr_raddr  (scr_raddr),
    .scr_rdata  (scr_rdata),
    .line_we    (line_we),
    .line_waddr (line_waddr),
    .line_wdata (line_wdata),
    .line_raddr (line_raddr),
    .line_rdata (line_rdata)
  );

  tcsb_screen_ram #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_screen (
    .clk  (clk),
    .we   (scr_we),
    .waddr(scr_waddr),
    .wdata(scr_wdata),
    .raddr(scr_raddr),
    .rdata(scr_rdata)
  );

  tcsb_line_buf #(
    .MAX_COLS(MAX_COLS)
  ) u_line (
    .clk  (clk),
    .rst  (rst),
    .we   (line_we),
    .waddr(line_waddr),
    .wdata(line_wdata),
    .raddr(line_raddr),
    .rdata(line_rdata)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/tcsb_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Console port checker
// Watches the command and result ports of the console scroll buffer.
// ----------------------------------------------------------------------------
module tcsb_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic [7:0] read_data,
  input wire logic       redraw
);

  // An accepted item either finishes at once or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted item neither finished nor held busy");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result strobe without an item in progress");

  a_redraw_strobe: assert property (@(posedge clk) disable iff (rst)
    (done && redraw) |-> $past(busy))
    else $error("redraw on a result without a commit pass");

  a_data_strobe: assert property (@(posedge clk) disable iff (rst)
    (done && (read_data != 8'd0)) |-> $past(busy))
    else $error("read data on a result that was not a read");

endmodule

bind text_console_scroll_buffer tcsb_checker u_tcsb_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .read_data(read_data),
  .redraw   (redraw)
);
`default_nettype wire
